// ----- rtl/core/ptpool_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpool_pkg
// Shared constants, codes and types of the point pool free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpool_pkg;

	localparam int SLOTS   = 1024;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int COORD_W = 32;

	localparam logic [COORD_W-1:0] INT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ALLOC_SET = 3'd0,
		OP_ALLOC     = 3'd1,
		OP_SET       = 3'd2,
		OP_CLEAR     = 3'd3,
		OP_DISPOSE   = 3'd4,
		OP_IS_ALLOC  = 3'd5,
		OP_EQUALS    = 3'd6,
		OP_IN_RECT   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef struct packed {
		logic               re;
		logic [IDX_W-1:0]   rd_addr;
		logic               we_x;
		logic               we_y;
		logic [IDX_W-1:0]   wr_addr;
		logic [COORD_W-1:0] wdata_x;
		logic [COORD_W-1:0] wdata_y;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptpool_ram.sv -----
// ----------------------------------------------------------------------------
// ptpool_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpool_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ptpool_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptpool_ctrl
// Command sequencer: issues the slot read at acceptance, then evaluates the
// opcode on the read data, writes the slot back and updates the chain head,
// high-water mark and live count.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpool_ctrl
	import ptpool_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire  [2:0]                opcode,
	input  wire  [IDX_W-1:0]          point_index,
	input  wire  signed [COORD_W-1:0] coord_x,
	input  wire  signed [COORD_W-1:0] coord_y,
	input  wire  signed [COORD_W-1:0] rect_x_high,
	input  wire  signed [COORD_W-1:0] rect_y_high,
	output logic                      done,
	output logic signed [IDX_W:0]     result_index,
	output logic                      query_flag,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          live_count,
	output mem_req_t                  mem_req,
	input  wire  [COORD_W-1:0]        rd_x,
	input  wire  [COORD_W-1:0]        rd_y
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                    state_q;
	op_t                       op_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, xh_q, yh_q;
	logic                      head_vld_q;
	logic [IDX_W-1:0]          head_q;
	logic [CNT_W-1:0]          hw_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic [IDX_W:0]            res_idx_q;
	logic                      flag_q;
	status_t                   status_q;

	logic                      accept;
	op_t                       op_in;
	logic                      pop, full, idx_ok, link_ok;
	logic [IDX_W-1:0]          slot;
	logic                      head_vld_d;
	logic [IDX_W-1:0]          head_d;
	logic [CNT_W-1:0]          hw_d, cnt_d;
	logic [IDX_W:0]            res_idx_d;
	logic                      flag_d;
	status_t                   status_d;
	logic                      we_x, we_y;
	logic [IDX_W-1:0]          wr_addr;
	logic [COORD_W-1:0]        wdata_x, wdata_y;

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign op_in  = op_t'(opcode);

	assign mem_req.re      = accept;
	assign mem_req.rd_addr = (op_in == OP_ALLOC_SET || op_in == OP_ALLOC) ? head_q : point_index;
	assign mem_req.we_x    = we_x;
	assign mem_req.we_y    = we_y;
	assign mem_req.wr_addr = wr_addr;
	assign mem_req.wdata_x = wdata_x;
	assign mem_req.wdata_y = wdata_y;

	assign pop     = head_vld_q && ({1'b0, head_q} < hw_q);
	assign full    = !pop && (hw_q == CNT_W'(SLOTS));
	assign slot    = pop ? head_q : hw_q[IDX_W-1:0];
	assign idx_ok  = {1'b0, idx_q} < hw_q;
	assign link_ok = !rd_x[COORD_W-1] && (rd_x[COORD_W-2:0] < (COORD_W-1)'(hw_q));

	always_comb begin
		head_vld_d = head_vld_q;
		head_d     = head_q;
		hw_d       = hw_q;
		cnt_d      = cnt_q;
		res_idx_d  = '1;
		flag_d     = 1'b0;
		status_d   = ST_OK;
		we_x       = 1'b0;
		we_y       = 1'b0;
		wr_addr    = idx_q;
		wdata_x    = cx_q;
		wdata_y    = cy_q;
		if (state_q == S_EXEC) begin
			if (op_q == OP_ALLOC_SET || op_q == OP_ALLOC) begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					if (pop) begin
						head_vld_d = link_ok;
						head_d     = rd_x[IDX_W-1:0];
					end else begin
						hw_d = hw_q + CNT_W'(1);
					end
					if (cnt_q < CNT_W'(SLOTS)) begin
						cnt_d = cnt_q + CNT_W'(1);
					end
					res_idx_d = {1'b0, slot};
					wr_addr   = slot;
					we_y      = 1'b1;
					we_x      = (op_q == OP_ALLOC_SET);
					wdata_y   = (op_q == OP_ALLOC_SET) ? cy_q : '0;
				end
			end else if (!idx_ok) begin
				status_d = ST_BAD_INDEX;
			end else begin
				unique case (op_q)
					OP_SET: begin
						we_x = 1'b1;
						we_y = 1'b1;
					end
					OP_CLEAR: begin
						we_x    = 1'b1;
						we_y    = 1'b1;
						wdata_x = '0;
						wdata_y = INT_MIN;
					end
					OP_DISPOSE: begin
						we_x       = 1'b1;
						we_y       = 1'b1;
						wdata_x    = head_vld_q ? COORD_W'(head_q) : '1;
						wdata_y    = INT_MIN;
						head_vld_d = 1'b1;
						head_d     = idx_q;
						if (cnt_q != '0) begin
							cnt_d = cnt_q - CNT_W'(1);
						end
					end
					OP_IS_ALLOC: begin
						flag_d = (rd_y != INT_MIN);
					end
					OP_EQUALS: begin
						flag_d = (rd_x == cx_q) && (rd_y == cy_q);
					end
					OP_IN_RECT: begin
						flag_d = ($signed(rd_x) >= cx_q) && ($signed(rd_x) <= xh_q) &&
						         ($signed(rd_y) >= cy_q) && ($signed(rd_y) <= yh_q);
					end
					default: begin
						flag_d = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_vld_q <= 1'b0;
			head_q     <= '0;
			hw_q       <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			res_idx_q  <= '1;
			flag_q     <= 1'b0;
			status_q   <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q    <= S_IDLE;
					head_vld_q <= head_vld_d;
					head_q     <= head_d;
					hw_q       <= hw_d;
					cnt_q      <= cnt_d;
					done_q     <= 1'b1;
					res_idx_q  <= res_idx_d;
					flag_q     <= flag_d;
					status_q   <= status_d;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			idx_q <= point_index;
			cx_q  <= coord_x;
			cy_q  <= coord_y;
			xh_q  <= rect_x_high;
			yh_q  <= rect_y_high;
		end
	end

	assign done         = done_q;
	assign result_index = $signed(res_idx_q);
	assign query_flag   = flag_q;
	assign status       = status_q;
	assign live_count   = cnt_q;

endmodule

`default_nettype wire

// ----- rtl/core/point_pool_free_list_top.sv -----
// ----------------------------------------------------------------------------
// point_pool_free_list_top
// Point table with a free-list slot allocator.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a command transfer happens on a rising edge with start
//   high and busy low. opcode, point_index and the coordinate fields are
//   sampled at that edge.
//   Result channel: done is high for exactly one cycle with result_index,
//   query_flag, status and live_count; the transfer completes at the edge
//   that ends that cycle. The receiver cannot stall this channel.
//   Sequencing: done rises at the edge after the command transfer (the edge
//   that accepts issues the slot read, the next one writes back and
//   registers the result). busy is high for the one cycle in between.
//   Overlap: no new command is taken while busy, during the read-modify-write
//   of the slot through the synchronous x/y RAMs; a new command may be taken in
//   the cycle that done is shown.
//   Reset: arst_n clears the chain head to empty, the high-water mark and
//   the live count to zero. The RAMs are not cleared; data read from slots
//   at or above the high-water mark is never used.
// ----------------------------------------------------------------------------
`default_nettype none

module point_pool_free_list_top
	import ptpool_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire  [2:0]                opcode,
	input  wire  [IDX_W-1:0]          point_index,
	input  wire  signed [COORD_W-1:0] coord_x,
	input  wire  signed [COORD_W-1:0] coord_y,
	input  wire  signed [COORD_W-1:0] rect_x_high,
	input  wire  signed [COORD_W-1:0] rect_y_high,
	output logic                      done,
	output logic signed [IDX_W:0]     result_index,
	output logic                      query_flag,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          live_count
);

	mem_req_t           mem_req;
	logic [COORD_W-1:0] rd_x, rd_y;

	ptpool_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.point_index  (point_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.rect_x_high  (rect_x_high),
		.rect_y_high  (rect_y_high),
		.done         (done),
		.result_index (result_index),
		.query_flag   (query_flag),
		.status       (status),
		.live_count   (live_count),
		.mem_req      (mem_req),
		.rd_x         (rd_x),
		.rd_y         (rd_y)
	);

	ptpool_ram #(.WIDTH(COORD_W), .DEPTH(SLOTS)) u_ram_x (
		.clk   (clk),
		.we    (mem_req.we_x),
		.waddr (mem_req.wr_addr),
		.wdata (mem_req.wdata_x),
		.re    (mem_req.re),
		.raddr (mem_req.rd_addr),
		.rdata (rd_x)
	);

	ptpool_ram #(.WIDTH(COORD_W), .DEPTH(SLOTS)) u_ram_y (
		.clk   (clk),
		.we    (mem_req.we_y),
		.waddr (mem_req.wr_addr),
		.wdata (mem_req.wdata_y),
		.re    (mem_req.re),
		.raddr (mem_req.rd_addr),
		.rdata (rd_y)
	);

endmodule

`default_nettype wire

// ----- rtl/core/ptpool_checker.sv -----
// ----------------------------------------------------------------------------
// ptpool_checker
// Port-level checks of the point pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptpool_checker
	import ptpool_pkg::*;
(
	input wire                       clk,
	input wire                       arst_n,
	input wire                       start,
	input wire                       busy,
	input wire                       done,
	input wire signed [IDX_W:0]      result_index,
	input wire [1:0]                 status,
	input wire [CNT_W-1:0]           live_count
);

	// every command transfer yields its result strobe once the execute state has passed
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing two cycles after transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (result_index == '1))
		else $error("pool full with an allocated index");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(live_count))
		else $error("live count changed without a result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		live_count <= CNT_W'(SLOTS))
		else $error("live count above capacity");

endmodule

bind point_pool_free_list_top ptpool_checker u_ptpool_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_index (result_index),
	.status       (status),
	.live_count   (live_count)
);

`default_nettype wire
